// ===== src/dmcl_pkg.sv =====
`default_nettype none

package dmcl_pkg;

   // default number of tag lines
   localparam int unsigned DEFAULT_LINES = 4096;

   // field widths
   localparam int unsigned ADDR_W     = 32;
   localparam int unsigned KIND_W     = 2;
   localparam int unsigned SIDE_W     = 2;
   localparam int unsigned COUNT_W    = 32;
   localparam int unsigned TAG_W      = 32;
   localparam int unsigned OFFSET_W   = 3;
   localparam int unsigned IBITS_W    = 4;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 4;

   // widest line index taken from the address
   localparam int unsigned IDX_W            = 12;
   localparam int unsigned UNIFIED_IBITS_MAX = 12;
   localparam int unsigned SPLIT_IBITS_MAX   = 11;

   // register reset values
   localparam logic [OFFSET_W-1:0] OFFSET_BITS_RST = 3'd3;
   localparam logic [IBITS_W-1:0]  INDEX_BITS_RST  = 4'd12;
   localparam logic                SPLIT_MODE_RST  = 1'b0;

   // access kinds; the unused code is a data access
   typedef enum logic [KIND_W-1:0] {
      KIND_DATA_READ   = 2'd0,
      KIND_DATA_WRITE  = 2'd1,
      KIND_INSTR_FETCH = 2'd2
   } kind_type;

   // which cache served the access
   typedef enum logic [SIDE_W-1:0] {
      SIDE_UNIFIED = 2'd0,
      SIDE_INSTR   = 2'd1,
      SIDE_DATA    = 2'd2
   } side_type;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OFFSET_BITS = 2'd0,
      CSR_INDEX_BITS  = 2'd1,
      CSR_SPLIT_MODE  = 2'd2
   } csr_index_type;

   // one tag line
   typedef struct packed {
      logic             line_valid;
      logic [TAG_W-1:0] line_tag;
   } tag_entry_type;

   // saturating increment
   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] value);
      logic [COUNT_W-1:0] result;
      result = (value == {COUNT_W{1'b1}}) ? value : value + COUNT_W'(1);
      return result;
   endfunction

endpackage

`default_nettype wire

// ===== src/dmcl_if.sv =====
`default_nettype none

// access request channel
interface dmcl_req_if;
   logic                           valid;
   logic                           ready;
   logic [dmcl_pkg::ADDR_W-1:0]    address;
   logic [dmcl_pkg::KIND_W-1:0]    access_kind;

   modport source (output valid, output address, output access_kind, input ready);
   modport sink   (input valid, input address, input access_kind, output ready);
endinterface

// lookup result channel
interface dmcl_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           hit;
   logic [dmcl_pkg::SIDE_W-1:0]    cache_side;
   logic [dmcl_pkg::COUNT_W-1:0]   access_count;
   logic [dmcl_pkg::COUNT_W-1:0]   hit_count;

   modport source (output valid, output hit, output cache_side, output access_count,
                   output hit_count, input ready);
   modport sink   (input valid, input hit, input cache_side, input access_count,
                   input hit_count, output ready);
endinterface

// configuration write channel
interface dmcl_csr_if;
   logic                             valid;
   logic                             ready;
   logic [dmcl_pkg::CSR_IDX_W-1:0]   index;
   logic [dmcl_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/dmcl_tag_store.sv =====
`default_nettype none

module dmcl_tag_store #(
   parameter int unsigned LINES = dmcl_pkg::DEFAULT_LINES,
   localparam int unsigned SLOT_W = $clog2(LINES)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          rd_en,
   input  wire logic [SLOT_W-1:0]             rd_slot,
   output dmcl_pkg::tag_entry_type            rd_entry,
   input  wire logic                          wr_en,
   input  wire logic [SLOT_W-1:0]             wr_slot,
   input  wire logic [dmcl_pkg::TAG_W-1:0]    wr_tag,
   output logic                               clr_busy
);

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(LINES - 1);

   dmcl_pkg::tag_entry_type tag_mem [LINES];
   dmcl_pkg::tag_entry_type rd_entry_ff;
   dmcl_pkg::tag_entry_type mem_wd;
   logic [SLOT_W-1:0]       mem_wa;
   logic                    mem_we;
   logic                    clr_busy_ff, clr_busy_in;
   logic [SLOT_W-1:0]       clr_slot_ff, clr_slot_in;

   // clearing sweep after reset, one line per cycle
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_slot_in = clr_slot_ff;
      if (clr_busy_ff) begin
         clr_slot_in = clr_slot_ff + SLOT_W'(1);
         if (clr_slot_ff == LAST_SLOT) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_slot_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_slot_ff <= clr_slot_in;
      end
   end

   // write port shared by the sweep and the miss fill
   always_comb begin
      mem_we = clr_busy_ff | wr_en;
      mem_wa = clr_busy_ff ? clr_slot_ff : wr_slot;
      mem_wd.line_valid = ~clr_busy_ff;
      mem_wd.line_tag   = clr_busy_ff ? '0 : wr_tag;
   end

   // tag memory with registered read; a fill to the same line this cycle is forwarded
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tag_mem[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         if (wr_en && (wr_slot == rd_slot)) begin
            rd_entry_ff.line_valid <= 1'b1;
            rd_entry_ff.line_tag   <= wr_tag;
         end else begin
            rd_entry_ff <= tag_mem[rd_slot];
         end
      end
   end

   assign rd_entry = rd_entry_ff;
   assign clr_busy = clr_busy_ff;

endmodule

`default_nettype wire

// ===== src/direct_mapped_cache_lookup_core.sv =====
`default_nettype none

// Direct-mapped cache tag lookup, unified or split into instruction and data halves.
// One access is accepted per cycle unless the result channel stalls; its result passes
// the request, lookup and result registers: the line index and tag are formed and the
// tag memory is read (one read port, registered data), then the stored tag is compared,
// the line filled on a miss and the saturating counters updated into the result register.
// Back-to-back accesses to the same line see each other's fill through a forwarding path.
// After reset the tag memory is cleared one line per cycle and no access is taken until
// it is done; configuration writes are taken at any time and must only be made while no
// access is in flight. Register writes never clear lines or counters.
module direct_mapped_cache_lookup_core #(
   parameter int unsigned LINES = dmcl_pkg::DEFAULT_LINES
) (
   input  wire logic  clock,
   input  wire logic  reset,
   dmcl_req_if.sink   req_ch,
   dmcl_rsp_if.source rsp_ch,
   dmcl_csr_if.sink   csr_ch
);

   localparam int unsigned SLOT_W     = $clog2(LINES);
   localparam int unsigned HALF_LINES = LINES / 2;
   localparam int unsigned SUM_W      = ((SLOT_W > dmcl_pkg::IDX_W) ? SLOT_W
                                                                   : dmcl_pkg::IDX_W) + 1;
   localparam logic [31:0] UNI_DIV  = 32'(LINES);
   localparam logic [31:0] HALF_DIV = 32'(HALF_LINES);
   localparam logic [SUM_W-1:0] HALF_BASE = SUM_W'(HALF_LINES);
   localparam int unsigned SHIFT_W = 5;

   // configuration registers
   logic [dmcl_pkg::OFFSET_W-1:0] offset_bits_ff, offset_bits_in;
   logic [dmcl_pkg::IBITS_W-1:0]  index_bits_ff, index_bits_in;
   logic                          split_mode_ff, split_mode_in;

   // request stage
   logic                          s0_valid_ff, s0_valid_in;
   logic [dmcl_pkg::ADDR_W-1:0]   s0_address_ff;
   logic [dmcl_pkg::KIND_W-1:0]   s0_kind_ff;

   // lookup stage
   logic                          s1_valid_ff, s1_valid_in;
   logic [SLOT_W-1:0]             s1_slot_ff;
   logic [dmcl_pkg::TAG_W-1:0]    s1_tag_ff;
   dmcl_pkg::side_type            s1_side_ff;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_hit_ff;
   dmcl_pkg::side_type            rsp_side_ff;
   logic [dmcl_pkg::COUNT_W-1:0]  rsp_access_ff, rsp_hits_ff;

   // counters
   logic [dmcl_pkg::COUNT_W-1:0]  iu_acc_ff, iu_acc_in, iu_hit_ff, iu_hit_in;
   logic [dmcl_pkg::COUNT_W-1:0]  d_acc_ff, d_acc_in, d_hit_ff, d_hit_in;
   logic [dmcl_pkg::COUNT_W-1:0]  sel_acc, sel_hit;

   // stage moves
   logic                          go1, go2, req_ready;
   logic                          clr_busy;

   // index and tag forming
   logic                          s0_instr;
   logic [dmcl_pkg::IBITS_W-1:0]  ib_eff;
   logic [SHIFT_W-1:0]            tag_shift;
   logic [dmcl_pkg::ADDR_W-1:0]   addr_shifted;
   logic [dmcl_pkg::IDX_W-1:0]    idx_mask, raw_idx, uni_rem, half_rem;
   logic [SUM_W-1:0]              slot_sum;
   logic [SLOT_W-1:0]             s0_slot;
   logic [dmcl_pkg::TAG_W-1:0]    s0_tag;
   dmcl_pkg::side_type            s0_side;

   // lookup compare
   dmcl_pkg::tag_entry_type       rd_entry;
   logic                          s1_hit;
   logic                          wr_en;

   // configuration writes
   assign csr_ch.ready = 1'b1;

   always_comb begin
      offset_bits_in = offset_bits_ff;
      index_bits_in  = index_bits_ff;
      split_mode_in  = split_mode_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            dmcl_pkg::CSR_OFFSET_BITS: offset_bits_in = csr_ch.data[dmcl_pkg::OFFSET_W-1:0];
            dmcl_pkg::CSR_INDEX_BITS:  index_bits_in  = csr_ch.data[dmcl_pkg::IBITS_W-1:0];
            dmcl_pkg::CSR_SPLIT_MODE:  split_mode_in  = csr_ch.data[0];
            default: ;
         endcase
      end
   end

   // pipeline advance
   assign go2       = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign go1       = s0_valid_ff && (!s1_valid_ff || go2);
   assign req_ready = !clr_busy && (!s0_valid_ff || go1);
   assign req_ch.ready = req_ready;

   // clamp index width, split address into index and tag
   always_comb begin
      s0_instr = (s0_kind_ff == dmcl_pkg::KIND_INSTR_FETCH);
      if (split_mode_ff) begin
         ib_eff  = (index_bits_ff > dmcl_pkg::IBITS_W'(dmcl_pkg::SPLIT_IBITS_MAX))
                   ? dmcl_pkg::IBITS_W'(dmcl_pkg::SPLIT_IBITS_MAX) : index_bits_ff;
         s0_side = s0_instr ? dmcl_pkg::SIDE_INSTR : dmcl_pkg::SIDE_DATA;
      end else begin
         ib_eff  = (index_bits_ff > dmcl_pkg::IBITS_W'(dmcl_pkg::UNIFIED_IBITS_MAX))
                   ? dmcl_pkg::IBITS_W'(dmcl_pkg::UNIFIED_IBITS_MAX) : index_bits_ff;
         s0_side = dmcl_pkg::SIDE_UNIFIED;
      end
      tag_shift    = SHIFT_W'(offset_bits_ff) + SHIFT_W'(ib_eff);
      addr_shifted = s0_address_ff >> offset_bits_ff;
      idx_mask     = ~({dmcl_pkg::IDX_W{1'b1}} << ib_eff);
      raw_idx      = addr_shifted[dmcl_pkg::IDX_W-1:0] & idx_mask;
      s0_tag       = s0_address_ff >> tag_shift;
   end

   // index modulo the lines of each cache, by constant conditional subtraction
   always_comb begin
      logic [31:0] uni_step;
      logic [31:0] half_step;
      uni_rem  = raw_idx;
      half_rem = raw_idx;
      for (int k = dmcl_pkg::IDX_W - 1; k >= 0; k--) begin
         uni_step  = UNI_DIV << k;
         half_step = HALF_DIV << k;
         if (uni_step <= 32'(uni_rem)) begin
            uni_rem = uni_rem - uni_step[dmcl_pkg::IDX_W-1:0];
         end
         if (half_step <= 32'(half_rem)) begin
            half_rem = half_rem - half_step[dmcl_pkg::IDX_W-1:0];
         end
      end
   end

   // line slot: data half sits above the instruction half
   always_comb begin
      if (!split_mode_ff) begin
         slot_sum = SUM_W'(uni_rem);
      end else if (s0_instr) begin
         slot_sum = SUM_W'(half_rem);
      end else begin
         slot_sum = SUM_W'(half_rem) + HALF_BASE;
      end
      s0_slot = slot_sum[SLOT_W-1:0];
   end

   dmcl_tag_store #(
      .LINES (LINES)
   ) u_tag_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (go1),
      .rd_slot  (s0_slot),
      .rd_entry (rd_entry),
      .wr_en    (wr_en),
      .wr_slot  (s1_slot_ff),
      .wr_tag   (s1_tag_ff),
      .clr_busy (clr_busy)
   );

   // tag compare and miss fill
   assign s1_hit = rd_entry.line_valid && (rd_entry.line_tag == s1_tag_ff);
   assign wr_en  = go2 && !s1_hit;

   // counter update for the cache used
   always_comb begin
      iu_acc_in = iu_acc_ff;
      iu_hit_in = iu_hit_ff;
      d_acc_in  = d_acc_ff;
      d_hit_in  = d_hit_ff;
      if (s1_side_ff == dmcl_pkg::SIDE_DATA) begin
         sel_acc = dmcl_pkg::sat_inc(d_acc_ff);
         sel_hit = s1_hit ? dmcl_pkg::sat_inc(d_hit_ff) : d_hit_ff;
         if (go2) begin
            d_acc_in = sel_acc;
            d_hit_in = sel_hit;
         end
      end else begin
         sel_acc = dmcl_pkg::sat_inc(iu_acc_ff);
         sel_hit = s1_hit ? dmcl_pkg::sat_inc(iu_hit_ff) : iu_hit_ff;
         if (go2) begin
            iu_acc_in = sel_acc;
            iu_hit_in = sel_hit;
         end
      end
   end

   // stage valid flags
   always_comb begin
      s0_valid_in  = s0_valid_ff;
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (go2) begin
         rsp_valid_in = 1'b1;
      end
      if (go2) begin
         s1_valid_in = 1'b0;
      end
      if (go1) begin
         s1_valid_in = 1'b1;
         s0_valid_in = 1'b0;
      end
      if (req_ch.valid && req_ready) begin
         s0_valid_in = 1'b1;
      end
   end

   // control and counter registers
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_bits_ff <= dmcl_pkg::OFFSET_BITS_RST;
         index_bits_ff  <= dmcl_pkg::INDEX_BITS_RST;
         split_mode_ff  <= dmcl_pkg::SPLIT_MODE_RST;
         s0_valid_ff    <= 1'b0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         iu_acc_ff      <= '0;
         iu_hit_ff      <= '0;
         d_acc_ff       <= '0;
         d_hit_ff       <= '0;
      end else begin
         offset_bits_ff <= offset_bits_in;
         index_bits_ff  <= index_bits_in;
         split_mode_ff  <= split_mode_in;
         s0_valid_ff    <= s0_valid_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         iu_acc_ff      <= iu_acc_in;
         iu_hit_ff      <= iu_hit_in;
         d_acc_ff       <= d_acc_in;
         d_hit_ff       <= d_hit_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ready) begin
         s0_address_ff <= req_ch.address;
         s0_kind_ff    <= req_ch.access_kind;
      end
      if (go1) begin
         s1_slot_ff <= s0_slot;
         s1_tag_ff  <= s0_tag;
         s1_side_ff <= s0_side;
      end
      if (go2) begin
         rsp_hit_ff    <= s1_hit;
         rsp_side_ff   <= s1_side_ff;
         rsp_access_ff <= sel_acc;
         rsp_hits_ff   <= sel_hit;
      end
   end

   // result channel
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.hit          = rsp_hit_ff;
   assign rsp_ch.cache_side   = rsp_side_ff;
   assign rsp_ch.access_count = rsp_access_ff;
   assign rsp_ch.hit_count    = rsp_hits_ff;

   // pipeline stays empty while the tag memory is being cleared
   assert property (@(posedge clock) disable iff (reset)
      clr_busy |-> (!s0_valid_ff && !s1_valid_ff && !rsp_valid_ff))
      else $error("access in flight during tag clear");

   // a repeat of the line just filled must hit through the forwarding path
   assert property (@(posedge clock) disable iff (reset)
      (go1 && go2 && (s0_slot == s1_slot_ff) && (s0_tag == s1_tag_ff)) |=> s1_hit)
      else $error("back-to-back access to filled line missed");

   // a reported hit count never exceeds the access count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_hits_ff <= rsp_access_ff))
      else $error("hit count above access count");

endmodule

`default_nettype wire
